// ----- rtl/mhpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants of the max-heap priority queue
// Sizes of the heap store, the command queue and the payload fields.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int unsigned DEPTH    = 128;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned CH_W     = IDX_W + 2;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic signed [VAL_W-1:0] EMPTY_VALUE = {VAL_W{1'b1}};

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e                     op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// ----- rtl/mhpq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_if: valid/ready channels of the max-heap priority queue
// Request channel (operation and value) and response channel.
// ----------------------------------------------------------------------------
interface mhpq_in_if import mhpq_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

interface mhpq_out_if import mhpq_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  logic [STATUS_W-1:0]     status;
  logic [COUNT_W-1:0]      count;

  modport source (output valid, output result_value, output status, output count,
                  input ready);
  modport sink (input valid, input result_value, input status, input count,
                output ready);
endinterface

// ----- rtl/mhpq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_front: request intake
// Decodes each request into a push or pop command and holds it in a
// two-entry queue until the heap engine takes it.
// ----------------------------------------------------------------------------
module mhpq_front import mhpq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mhpq_in_if.sink    in_i,
  output q_head_t    head_o,
  input  logic       pop_i
);

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              push;
  logic              pop;
  cmd_t              cmd_in;

  assign in_i.ready = (fill_q != QCNT_W'(QDEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (fill_q != '0);

  assign cmd_in.op    = op_e'(in_i.action);
  assign cmd_in.value = in_i.value;

  assign head_o.valid = (fill_q != '0);
  assign head_o.cmd   = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + QCNT_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ----- rtl/mhpq_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_engine: heap store and sift sequencer
// Runs one command at a time against the heap memory: sift-up for a push,
// root removal and sift-down for a pop, then loads the response register.
// ----------------------------------------------------------------------------
module mhpq_engine import mhpq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_head_t    head_i,
  output logic       pop_o,
  mhpq_out_if.source out_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_UPC  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_DOWN = 3'd4;
  localparam logic [2:0] S_DNC  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic signed [VAL_W-1:0] heap_mem [DEPTH];

  logic [2:0]              state_q, state_d;
  logic [IDX_W-1:0]        pos_q, pos_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [VAL_W-1:0] x_q, x_d;
  logic signed [VAL_W-1:0] res_q, res_d;
  status_e                 status_q, status_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] out_value_q, out_value_d;
  status_e                 out_status_q, out_status_d;
  logic [COUNT_W-1:0]      out_count_q, out_count_d;

  logic [IDX_W-1:0]        rd_a_addr, rd_b_addr, wr_addr;
  logic signed [VAL_W-1:0] rd_a_q, rd_b_q, wr_data;
  logic                    wr_en;

  logic [IDX_W-1:0]        parent;
  logic [CH_W-1:0]         child_l, child_r;
  logic                    l_valid, r_valid, take_l, take_r;
  logic signed [VAL_W-1:0] best_val;
  logic                    out_free;

  assign parent   = (pos_q - IDX_W'(1)) >> 1;
  assign child_l  = {1'b0, pos_q, 1'b1};
  assign child_r  = child_l + CH_W'(1);
  assign l_valid  = child_l < CH_W'(cnt_q);
  assign r_valid  = child_r < CH_W'(cnt_q);
  // left child wins a tie, and a child moves up only when strictly greater
  assign take_l   = l_valid && (rd_a_q > x_q);
  assign best_val = take_l ? rd_a_q : x_q;
  assign take_r   = r_valid && (rd_b_q > best_val);
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    x_d          = x_q;
    res_d        = res_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    rd_a_addr    = '0;
    rd_b_addr    = '0;
    wr_addr      = pos_q;
    wr_data      = x_q;
    wr_en        = 1'b0;
    pop_o        = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o    = 1'b1;
          x_d      = head_i.cmd.value;
          res_d    = '0;
          status_d = ST_OK;
          if (head_i.cmd.op == OP_PUSH) begin
            if (cnt_q == CNT_W'(DEPTH)) begin
              status_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              pos_d   = cnt_q[IDX_W-1:0];
              state_d = S_UP;
            end
          end else begin
            if (cnt_q == '0) begin
              res_d    = EMPTY_VALUE;
              status_d = ST_EMPTY;
              state_d  = S_FIN;
            end else begin
              rd_a_addr = '0;
              rd_b_addr = IDX_W'(cnt_q - CNT_W'(1));
              state_d   = S_LOAD;
            end
          end
        end
      end
      S_UP: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_FIN;
        end else begin
          rd_a_addr = parent;
          state_d   = S_UPC;
        end
      end
      S_UPC: begin
        wr_en = 1'b1;
        if (x_q > rd_a_q) begin
          // parent moves down into the hole
          wr_data = rd_a_q;
          pos_d   = parent;
          state_d = S_UP;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_FIN;
        end
      end
      S_LOAD: begin
        res_d = rd_a_q;
        x_d   = rd_b_q;
        cnt_d = cnt_q - CNT_W'(1);
        pos_d = '0;
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_FIN;
        end else begin
          state_d = S_DOWN;
        end
      end
      S_DOWN: begin
        rd_a_addr = child_l[IDX_W-1:0];
        rd_b_addr = child_r[IDX_W-1:0];
        state_d   = S_DNC;
      end
      S_DNC: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data = rd_b_q;
          pos_d   = child_r[IDX_W-1:0];
          state_d = S_DOWN;
        end else if (take_l) begin
          wr_data = rd_a_q;
          pos_d   = child_l[IDX_W-1:0];
          state_d = S_DOWN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_q;
          out_status_d = status_q;
          out_count_d  = COUNT_W'(cnt_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    x_q          <= x_d;
    res_q        <= res_d;
    status_q     <= status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_a_q <= heap_mem[rd_a_addr];
    rd_b_q <= heap_mem[rd_b_addr];
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_value_q;
  assign out_o.status       = out_status_q;
  assign out_o.count        = out_count_q;

endmodule

// ----- rtl/max_heap_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue: bounded binary max-heap of signed 32-bit values
// Operations: a push climbs from the tail level by level while it is greater
//   than the parent; a pop takes the root and sinks the last entry level by
//   level; a dropped insert or an empty extract goes straight to the response.
// One operation runs at a time; the two-entry intake queue holds new requests.
// Reset: clears the entry count and the queues; heap memory is not cleared.
// ----------------------------------------------------------------------------
module max_heap_priority_queue import mhpq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mhpq_in_if.sink    in_i,
  mhpq_out_if.source out_o
);

  q_head_t head;
  logic    pop;

  mhpq_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  mhpq_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("command taken from an empty queue");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_FULL) |->
      (out_o.count == COUNT_W'(DEPTH) && out_o.result_value == '0))
    else $error("full status with wrong count or value");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_EMPTY) |->
      (out_o.count == '0 && out_o.result_value == EMPTY_VALUE))
    else $error("empty status with wrong count or value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.result_value)))
    else $error("stalled response changed");

endmodule

// ----- tb/mhpq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_checker: response scoreboard of the max-heap priority queue
// Watches both channels, keeps its own image of the heap, predicts the
// response of every accepted operation and compares each response field.
// ----------------------------------------------------------------------------
module mhpq_checker import mhpq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mhpq_in_if          req_i,
  mhpq_out_if         rsp_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned drops_o,
  output int unsigned underflows_o,
  output int unsigned peak_o
);

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    status_e                 status;
    logic [COUNT_W-1:0]      count;
  } heap_resp_t;

  logic signed [VAL_W-1:0] heap_img [DEPTH];
  int unsigned             fill;
  heap_resp_t              resp_fifo [$];
  heap_resp_t              want;

  int unsigned err_cnt, open_cnt, chk_cnt, drop_cnt, under_cnt, peak_cnt;

  assign errors_o     = err_cnt;
  assign pending_o    = open_cnt;
  assign checked_o    = chk_cnt;
  assign drops_o      = drop_cnt;
  assign underflows_o = under_cnt;
  assign peak_o       = peak_cnt;

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_cnt++;
  endtask

  // Insert at the tail, climb while strictly greater than the parent.
  function automatic heap_resp_t push_op(input logic signed [VAL_W-1:0] v);
    heap_resp_t              r;
    int unsigned             pos;
    int unsigned             up;
    logic signed [VAL_W-1:0] tmp;
    r.result_value = '0;
    if (fill >= DEPTH) begin
      r.status = ST_FULL;
    end else begin
      r.status = ST_OK;
      heap_img[fill] = v;
      pos = fill;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (heap_img[pos] <= heap_img[up]) break;
        tmp           = heap_img[pos];
        heap_img[pos] = heap_img[up];
        heap_img[up]  = tmp;
        pos           = up;
      end
      fill++;
    end
    r.count = fill[COUNT_W-1:0];
    return r;
  endfunction

  // Take the root, move the tail up, sink it; left child wins a tie.
  function automatic heap_resp_t pop_op();
    heap_resp_t              r;
    int unsigned             pos;
    int unsigned             best;
    int unsigned             lc;
    int unsigned             rc;
    logic signed [VAL_W-1:0] tmp;
    if (fill == 0) begin
      r.result_value = EMPTY_VALUE;
      r.status       = ST_EMPTY;
    end else begin
      r.result_value = heap_img[0];
      r.status       = ST_OK;
      heap_img[0]    = heap_img[fill-1];
      fill--;
      pos = 0;
      while (pos < fill) begin
        best = pos;
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        if (lc < fill && heap_img[lc] > heap_img[best]) best = lc;
        if (rc < fill && heap_img[rc] > heap_img[best]) best = rc;
        if (best == pos) break;
        tmp            = heap_img[pos];
        heap_img[pos]  = heap_img[best];
        heap_img[best] = tmp;
        pos            = best;
      end
    end
    r.count = fill[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill      = 0;
      err_cnt   = 0;
      open_cnt  = 0;
      chk_cnt   = 0;
      drop_cnt  = 0;
      under_cnt = 0;
      peak_cnt  = 0;
      resp_fifo.delete();
    end else begin
      // predict first so a same-edge response still finds its entry
      if (req_i.valid && req_i.ready) begin
        if (op_e'(req_i.action) == OP_PUSH) begin
          want = push_op(req_i.value);
        end else begin
          want = pop_op();
        end
        if (want.status == ST_FULL) drop_cnt++;
        if (want.status == ST_EMPTY) under_cnt++;
        if (fill > peak_cnt) peak_cnt = fill;
        resp_fifo.push_back(want);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        chk_cnt++;
        if (resp_fifo.size() == 0) begin
          report("response transfer with no operation outstanding");
        end else begin
          want = resp_fifo.pop_front();
          if (rsp_i.result_value !== want.result_value) begin
            report($sformatf("result_value: expected %0d, got %0d",
                             want.result_value, rsp_i.result_value));
          end
          if (rsp_i.status !== want.status) begin
            report($sformatf("status: expected %0d, got %0d", want.status, rsp_i.status));
          end
          if (rsp_i.count !== want.count) begin
            report($sformatf("count: expected %0d, got %0d", want.count, rsp_i.count));
          end
        end
      end
      open_cnt = resp_fifo.size();
    end
  end

endmodule

// ----- tb/tb_max_heap_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue: testbench of the max-heap priority queue
// Drives directed and phased random insert/extract traffic with random
// idling on both channels and one long response stall; the checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue;
  import mhpq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned RAND_OPS     = 930;
  localparam int unsigned QUIET_FROM   = 820;  // no idling past this many transfers
  localparam int unsigned HOLD_AT      = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  int unsigned sent_cnt  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned errors, pending, checked, drops, underflows, peak;

  mhpq_in_if  req_if ();
  mhpq_out_if rsp_if ();

  max_heap_priority_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  mhpq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .errors_o     (errors),
    .pending_o    (pending),
    .checked_o    (checked),
    .drops_o      (drops),
    .underflows_o (underflows),
    .peak_o       (peak)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Extremes and a narrow band around zero, so ties show up often.
  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(0, 8) - 4;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_op(input op_e op, input logic signed [VAL_W-1:0] v);
    if (sent_cnt < QUIET_FROM && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= op;
    req_if.value  <= v;
    do @(posedge clk_i); while (!req_if.ready);
    sent_cnt++;
  endtask

  // Response side: random stalls plus one long hold-off that backs up the queue.
  initial begin
    bit held;
    held = 1'b0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && sent_cnt >= HOLD_AT) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (sent_cnt < QUIET_FROM && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    op_e         op;
    int unsigned push_pct;
    req_if.valid  <= 1'b0;
    req_if.action <= OP_PUSH;
    req_if.value  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extract on empty, extremes, ties at both ends, then drain past empty
    send_op(OP_POP, 32'h0000_0000);
    send_op(OP_PUSH, 32'h7FFF_FFFF);
    send_op(OP_PUSH, 32'h8000_0000);
    send_op(OP_PUSH, 32'h0000_0000);
    send_op(OP_PUSH, 32'hFFFF_FFFF);
    send_op(OP_PUSH, 32'h0000_0005);
    send_op(OP_PUSH, 32'h0000_0005);
    send_op(OP_PUSH, 32'h0000_0005);
    send_op(OP_PUSH, 32'h7FFF_FFFF);
    send_op(OP_PUSH, 32'h8000_0000);
    repeat (10) send_op(OP_POP, rand_value());

    // fill past full, drain past empty, then mixed traffic
    for (int i = 0; i < RAND_OPS; i++) begin
      if (i < 200) push_pct = 85;
      else if (i < 400) push_pct = 15;
      else if (i < 650) push_pct = 50;
      else if (i < 780) push_pct = 80;
      else push_pct = 35;
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      send_op(op, rand_value());
    end
    req_if.valid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run: %0d operations sent, %0d responses checked, heap peaked at %0d entries.",
             sent_cnt, checked, peak);
    $display("Run: %0d inserts dropped on a full heap, %0d extracts from an empty heap.",
             drops, underflows);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
